[hw/rtl/mvsm_pkg.sv]
// Package for the multi-voice sample mixer: sizes, field widths, codes,
// command and state types. No dependencies.
package mvsm_pkg;

   localparam int VOICE_COUNT   = 16;
   localparam int SOUND_COUNT   = 64;
   localparam int SAMPLE_WORDS  = 65536;
   localparam int FRACTION_BITS = 16;

   localparam int VOICE_IDX_W   = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
   localparam int SOUND_IDX_W   = (SOUND_COUNT > 1) ? $clog2(SOUND_COUNT) : 1;
   localparam int SAMPLE_ADDR_W = $clog2(SAMPLE_WORDS);

   localparam int OPCODE_W = 3;
   localparam int ADDR_W   = 16;
   localparam int WORD_W   = 16;
   localparam int SOUND_W  = 6;
   localparam int START_W  = 16;
   localparam int SIZE_W   = 17;
   localparam int SPEED_W  = 20;
   localparam int KIND_W   = 3;
   localparam int SLOT_W   = 4;

   localparam int POS_W    = SIZE_W + FRACTION_BITS + 1;
   localparam int SUM_W    = SIZE_W + 2;

   localparam int FRAME_LEN_W   = 14;
   localparam int FRAME_CNT_W   = 13;
   localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_MAX   = 14'd8192;
   localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_RESET = 14'd1024;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_LENGTH = '0;

   localparam int CMD_FIFO_DEPTH = 2;
   localparam int CMD_PTR_W      = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
   localparam int CMD_CNT_W      = $clog2(CMD_FIFO_DEPTH + 1);

   typedef enum logic [OPCODE_W-1:0] {
      OP_WRITE_SAMPLE = 3'd0,
      OP_DEFINE_SOUND = 3'd1,
      OP_PLAY         = 3'd2,
      OP_TICK         = 3'd3,
      OP_FLUSH        = 3'd4
   } opcode_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_SAMPLE   = 3'd0,
      KIND_FLUSH    = 3'd1,
      KIND_STARTED  = 3'd2,
      KIND_UNKNOWN  = 3'd3,
      KIND_NO_VOICE = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ENG_IDLE,
      ENG_TICK_A,
      ENG_TICK_B,
      ENG_TICK_C,
      ENG_PLAY_A,
      ENG_PLAY_B,
      ENG_EMIT
   } eng_state_type;

   typedef struct packed {
      opcode_type                op;
      logic [ADDR_W-1:0]         mem_address;
      logic signed [WORD_W-1:0]  sample_word;
      logic [SOUND_W-1:0]        sound_number;
      logic [START_W-1:0]        sound_start;
      logic [SIZE_W-1:0]         sound_size;
      logic [SPEED_W-1:0]        play_speed;
   } cmd_type;

   // Handshake between the command queue and the engine.
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_chan_type;

endpackage

[hw/rtl/mvsm_if.sv]
// Channel interfaces of the mixer: request and response with valid/ready.
// Depends on mvsm_pkg.
interface mvsm_req_if import mvsm_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [OPCODE_W-1:0]      opcode;
   logic [ADDR_W-1:0]        mem_address;
   logic signed [WORD_W-1:0] sample_word;
   logic [SOUND_W-1:0]       sound_number;
   logic [START_W-1:0]       sound_start;
   logic [SIZE_W-1:0]        sound_size;
   logic [SPEED_W-1:0]       play_speed;

   modport source (output valid, opcode, mem_address, sample_word, sound_number,
                   sound_start, sound_size, play_speed, input ready);
   modport sink   (input valid, opcode, mem_address, sample_word, sound_number,
                   sound_start, sound_size, play_speed, output ready);
endinterface

interface mvsm_rsp_if import mvsm_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [KIND_W-1:0]        result_kind;
   logic signed [WORD_W-1:0] mixed_sample;
   logic                     frame_end;
   logic [SLOT_W-1:0]        voice_slot;

   modport source (output valid, result_kind, mixed_sample, frame_end, voice_slot,
                   input ready);
   modport sink   (input valid, result_kind, mixed_sample, frame_end, voice_slot,
                   output ready);
endinterface

[hw/rtl/mvsm_front.sv]
// Front end of the mixer: accepts request transactions, drops unused opcodes
// and packs the rest into commands. Depends on mvsm_pkg and mvsm_if.
module mvsm_front import mvsm_pkg::*; (
   mvsm_req_if.sink req,
   input  logic     fifo_full,
   output logic     push,
   output cmd_type  cmd
);

   logic known_op;

   always_comb begin
      known_op  = req.opcode inside {[OP_WRITE_SAMPLE:OP_FLUSH]};
      req.ready = !fifo_full;
      push      = req.valid && !fifo_full && known_op;

      cmd.op           = opcode_type'(req.opcode);
      cmd.mem_address  = req.mem_address;
      cmd.sample_word  = req.sample_word;
      cmd.sound_number = req.sound_number;
      cmd.sound_start  = req.sound_start;
      cmd.sound_size   = req.sound_size;
      cmd.play_speed   = req.play_speed;
   end

endmodule

[hw/rtl/mvsm_cmd_fifo.sv]
// Short command queue between the front end and the engine.
// Depends on mvsm_pkg.
module mvsm_cmd_fifo import mvsm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  cmd_type      push_cmd,
   input  logic         pop,
   output cmd_chan_type head,
   output logic         full
);

   cmd_type               entry_ff [CMD_FIFO_DEPTH];
   logic [CMD_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0]  count_ff, count_in;
   logic                  do_push, do_pop;

   always_comb begin
      full       = (count_ff == CMD_CNT_W'(CMD_FIFO_DEPTH));
      head.valid = (count_ff != '0);
      head.cmd   = entry_ff[rd_ptr_ff];
      do_push    = push && !full;
      do_pop     = pop && head.valid;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == CMD_PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == CMD_PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[hw/rtl/mvsm_engine.sv]
// Back end of the mixer: sample memory, sound tables, voice slots, the
// slot walk for tick and play, and the response register. Depends on mvsm_pkg, mvsm_if.
module mvsm_engine import mvsm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_chan_type           head,
   output logic                   cmd_pop,
   input  logic [FRAME_LEN_W-1:0] frame_length,
   mvsm_rsp_if.source             rsp
);

   localparam logic [VOICE_IDX_W-1:0] LAST_SLOT = VOICE_IDX_W'(VOICE_COUNT - 1);

   eng_state_type               state_ff, state_in;
   logic [VOICE_IDX_W-1:0]      slot_ff, slot_in;
   cmd_type                     cmd_ff, cmd_in;
   logic signed [WORD_W-1:0]    acc_ff, acc_in;
   logic [FRAME_CNT_W-1:0]      count_ff, count_in;
   logic                        active_ff, active_in;

   kind_type                    res_kind_ff, res_kind_in;
   logic signed [WORD_W-1:0]    res_sample_ff, res_sample_in;
   logic                        res_fend_ff, res_fend_in;
   logic [SLOT_W-1:0]           res_slot_ff, res_slot_in;

   logic                        out_valid_ff, out_valid_in;
   kind_type                    out_kind_ff, out_kind_in;
   logic signed [WORD_W-1:0]    out_sample_ff, out_sample_in;
   logic                        out_fend_ff, out_fend_in;
   logic [SLOT_W-1:0]           out_slot_ff, out_slot_in;

   logic                        voice_used_ff  [VOICE_COUNT];
   logic [SOUND_W-1:0]          voice_sound_ff [VOICE_COUNT];
   logic [POS_W-1:0]            voice_pos_ff   [VOICE_COUNT];
   logic [SPEED_W-1:0]          voice_speed_ff [VOICE_COUNT];
   logic                        sound_defined_ff [SOUND_COUNT];

   logic [START_W-1:0]          start_mem  [SOUND_COUNT];
   logic [SIZE_W-1:0]           size_mem   [SOUND_COUNT];
   logic signed [WORD_W-1:0]    sample_mem [SAMPLE_WORDS];
   logic [START_W-1:0]          start_q_ff;
   logic [SIZE_W-1:0]           size_q_ff;
   logic signed [WORD_W-1:0]    sample_q_ff;

   logic [SOUND_W-1:0]          cur_sound;
   logic [SOUND_IDX_W-1:0]      cur_idx;
   logic                        cur_active;
   logic [POS_W-1:0]            cur_pos;
   logic [SUM_W-1:0]            addr_sum;
   logic [SAMPLE_ADDR_W-1:0]    sample_rd_addr;
   logic [SOUND_IDX_W-1:0]      head_idx;
   logic                        head_in_range;
   logic                        head_snd_ok;
   logic signed [WORD_W+1:0]    twice_sum;
   logic signed [WORD_W+1:0]    rounded;
   logic signed [WORD_W:0]      halved;
   logic signed [WORD_W-1:0]    acc_next;
   logic [FRAME_LEN_W-1:0]      fl_eff;
   logic [FRAME_LEN_W-1:0]      cnt_inc;
   logic                        out_free;
   logic                        sample_wr, table_wr, voice_claim, voice_advance;

   always_comb begin
      cur_sound  = voice_sound_ff[slot_ff];
      cur_idx    = SOUND_IDX_W'(cur_sound);
      cur_pos    = voice_pos_ff[slot_ff];
      cur_active = voice_used_ff[slot_ff] && (int'(cur_sound) < SOUND_COUNT)
                   && sound_defined_ff[cur_idx]
                   && (cur_pos < POS_W'({size_q_ff, {FRACTION_BITS{1'b0}}}));
      addr_sum   = SUM_W'(start_q_ff) + SUM_W'(cur_pos[POS_W-1:FRACTION_BITS]);
      sample_rd_addr = SAMPLE_ADDR_W'(addr_sum);

      head_idx      = SOUND_IDX_W'(head.cmd.sound_number);
      head_in_range = int'(head.cmd.sound_number) < SOUND_COUNT;
      head_snd_ok   = head_in_range && sound_defined_ff[head_idx];

      // (2*acc + sample) / 2 with truncation toward zero, then clamp to 16 bits.
      twice_sum = $signed({acc_ff[WORD_W-1], acc_ff, 1'b0})
                  + $signed({{2{sample_q_ff[WORD_W-1]}}, sample_q_ff});
      rounded   = twice_sum + $signed({{(WORD_W+1){1'b0}}, twice_sum[WORD_W+1]});
      halved    = rounded[WORD_W+1:1];
      if (halved > $signed(17'sd32767)) begin
         acc_next = 16'sh7FFF;
      end else if (halved < -$signed(17'sd32768)) begin
         acc_next = 16'sh8000;
      end else begin
         acc_next = halved[WORD_W-1:0];
      end

      if (frame_length == '0) begin
         fl_eff = FRAME_LEN_W'(1);
      end else if (frame_length > FRAME_LEN_MAX) begin
         fl_eff = FRAME_LEN_MAX;
      end else begin
         fl_eff = frame_length;
      end
      cnt_inc = FRAME_LEN_W'(count_ff) + 1'b1;

      out_free = !out_valid_ff || rsp.ready;
   end

   always_comb begin
      state_in      = state_ff;
      slot_in       = slot_ff;
      cmd_in        = cmd_ff;
      acc_in        = acc_ff;
      count_in      = count_ff;
      active_in     = active_ff;
      res_kind_in   = res_kind_ff;
      res_sample_in = res_sample_ff;
      res_fend_in   = res_fend_ff;
      res_slot_in   = res_slot_ff;
      out_valid_in  = out_valid_ff && !rsp.ready;
      out_kind_in   = out_kind_ff;
      out_sample_in = out_sample_ff;
      out_fend_in   = out_fend_ff;
      out_slot_in   = out_slot_ff;
      cmd_pop       = 1'b0;
      sample_wr     = 1'b0;
      table_wr      = 1'b0;
      voice_claim   = 1'b0;
      voice_advance = 1'b0;

      case (state_ff)
         ENG_IDLE: begin
            if (head.valid) begin
               cmd_pop = 1'b1;
               cmd_in  = head.cmd;
               case (head.cmd.op)
                  OP_WRITE_SAMPLE: begin
                     sample_wr = 1'b1;
                  end
                  OP_DEFINE_SOUND: begin
                     table_wr = head_in_range;
                  end
                  OP_PLAY: begin
                     if (head_snd_ok) begin
                        slot_in  = '0;
                        state_in = ENG_PLAY_A;
                     end else begin
                        res_kind_in   = KIND_UNKNOWN;
                        res_sample_in = '0;
                        res_fend_in   = 1'b0;
                        res_slot_in   = '0;
                        state_in      = ENG_EMIT;
                     end
                  end
                  OP_TICK: begin
                     slot_in  = '0;
                     acc_in   = '0;
                     state_in = ENG_TICK_A;
                  end
                  OP_FLUSH: begin
                     count_in      = '0;
                     res_kind_in   = KIND_FLUSH;
                     res_sample_in = '0;
                     res_fend_in   = 1'b1;
                     res_slot_in   = '0;
                     state_in      = ENG_EMIT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ENG_TICK_A: begin
            state_in = ENG_TICK_B;
         end
         ENG_TICK_B: begin
            active_in     = cur_active;
            voice_advance = cur_active;
            state_in      = ENG_TICK_C;
         end
         ENG_TICK_C: begin
            if (active_ff) begin
               acc_in = acc_next;
            end
            if (slot_ff == LAST_SLOT) begin
               res_kind_in   = KIND_SAMPLE;
               res_sample_in = active_ff ? acc_next : acc_ff;
               res_slot_in   = '0;
               if (cnt_inc >= fl_eff) begin
                  count_in    = '0;
                  res_fend_in = 1'b1;
               end else begin
                  count_in    = cnt_inc[FRAME_CNT_W-1:0];
                  res_fend_in = 1'b0;
               end
               state_in = ENG_EMIT;
            end else begin
               slot_in  = slot_ff + 1'b1;
               state_in = ENG_TICK_A;
            end
         end
         ENG_PLAY_A: begin
            state_in = ENG_PLAY_B;
         end
         ENG_PLAY_B: begin
            res_sample_in = '0;
            res_fend_in   = 1'b0;
            if (!cur_active) begin
               voice_claim = 1'b1;
               res_kind_in = KIND_STARTED;
               res_slot_in = SLOT_W'(slot_ff);
               state_in    = ENG_EMIT;
            end else if (slot_ff == LAST_SLOT) begin
               res_kind_in = KIND_NO_VOICE;
               res_slot_in = '0;
               state_in    = ENG_EMIT;
            end else begin
               slot_in  = slot_ff + 1'b1;
               state_in = ENG_PLAY_A;
            end
         end
         ENG_EMIT: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_kind_in   = res_kind_ff;
               out_sample_in = res_sample_ff;
               out_fend_in   = res_fend_ff;
               out_slot_in   = res_slot_ff;
               state_in      = ENG_IDLE;
            end
         end
         default: begin
            state_in = ENG_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ENG_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff       <= slot_in;
      cmd_ff        <= cmd_in;
      acc_ff        <= acc_in;
      active_ff     <= active_in;
      res_kind_ff   <= res_kind_in;
      res_sample_ff <= res_sample_in;
      res_fend_ff   <= res_fend_in;
      res_slot_ff   <= res_slot_in;
      out_kind_ff   <= out_kind_in;
      out_sample_ff <= out_sample_in;
      out_fend_ff   <= out_fend_in;
      out_slot_ff   <= out_slot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < VOICE_COUNT; i++) begin
            voice_used_ff[i] <= 1'b0;
         end
         for (int i = 0; i < SOUND_COUNT; i++) begin
            sound_defined_ff[i] <= 1'b0;
         end
      end else begin
         if (voice_claim) begin
            voice_used_ff[slot_ff] <= 1'b1;
         end
         if (table_wr) begin
            sound_defined_ff[head_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (voice_claim) begin
         voice_sound_ff[slot_ff] <= cmd_ff.sound_number;
         voice_pos_ff[slot_ff]   <= '0;
         voice_speed_ff[slot_ff] <= cmd_ff.play_speed;
      end else if (voice_advance) begin
         voice_pos_ff[slot_ff] <= cur_pos + POS_W'(voice_speed_ff[slot_ff]);
      end
   end

   always_ff @(posedge clock) begin
      if (table_wr) begin
         start_mem[head_idx] <= head.cmd.sound_start;
         size_mem[head_idx]  <= head.cmd.sound_size;
      end
      start_q_ff <= start_mem[cur_idx];
      size_q_ff  <= size_mem[cur_idx];
   end

   always_ff @(posedge clock) begin
      if (sample_wr) begin
         sample_mem[SAMPLE_ADDR_W'(head.cmd.mem_address)] <= head.cmd.sample_word;
      end
      sample_q_ff <= sample_mem[sample_rd_addr];
   end

   always_comb begin
      rsp.valid        = out_valid_ff;
      rsp.result_kind  = out_kind_ff;
      rsp.mixed_sample = out_sample_ff;
      rsp.frame_end    = out_fend_ff;
      rsp.voice_slot   = out_slot_ff;
   end

endmodule

[hw/rtl/multi_voice_sample_mixer.sv]
// Top level of the multi-voice sample mixer: front end, command queue,
// engine and the frame length register. Depends on mvsm_pkg, mvsm_if and submodules.
//
// Usage. Commands arrive as transactions on the req channel (valid/ready) and
// results leave as transactions on the rsp channel. Sample writes and sound
// definitions give no result; play, tick and flush give exactly one. Unused
// opcodes are taken and dropped. The frame length register sits at byte
// address 0 of the APB-style port and is written at the access phase.
// Command handling: a sample write or sound definition is done in ENG_IDLE,
// so the engine stays idle and ready for the next command. A tick walks all
// voice slots through ENG_TICK_A, ENG_TICK_B and ENG_TICK_C per slot (voice
// read and sound table read, sample memory read, accumulate); the last slot
// fills the result register and ENG_EMIT passes it on. A play scans slots
// through ENG_PLAY_A and ENG_PLAY_B per slot until it finds a free one or
// passes the last. The registered table and memory reads need these states.
// Reset clears the queue, all voice slots, the sound definitions and the
// frame counter, and sets frame length to 1024. The sample memory is not
// cleared. When the receiver stalls, the result waits in the output register
// while the queue keeps accepting transactions until it is full.
module multi_voice_sample_mixer import mvsm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   mvsm_req_if.sink              req,
   mvsm_rsp_if.source            rsp,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [FRAME_LEN_W-1:0] frame_length_ff, frame_length_in;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic                   csr_write;
   logic                   push;
   logic                   fifo_full;
   logic                   cmd_pop;
   cmd_type                push_cmd;
   cmd_chan_type           head;

   // The register index is the word address; a write elsewhere is ignored.
   always_comb begin
      csr_index       = paddr[CSR_ADDR_W-1:2];
      pready          = 1'b1;
      csr_write       = psel && penable && pwrite;
      frame_length_in = frame_length_ff;
      if (csr_write && (csr_index == CSR_FRAME_LENGTH)) begin
         frame_length_in = pwdata[FRAME_LEN_W-1:0];
      end
      if (csr_index == CSR_FRAME_LENGTH) begin
         prdata = CSR_DATA_W'(frame_length_ff);
      end else begin
         prdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff <= FRAME_LEN_RESET;
      end else begin
         frame_length_ff <= frame_length_in;
      end
   end

   // The front end only decodes; the queue decouples it from the engine so
   // new transactions are taken while a tick walks the voice slots.
   mvsm_front u_front (
      .req       (req),
      .fifo_full (fifo_full),
      .push      (push),
      .cmd       (push_cmd)
   );

   mvsm_cmd_fifo u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (cmd_pop),
      .head     (head),
      .full     (fifo_full)
   );

   mvsm_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .cmd_pop      (cmd_pop),
      .frame_length (frame_length_ff),
      .rsp          (rsp)
   );

endmodule

[hw/rtl/mvsm_checker.sv]
// Port-level assertions for the mixer, attached to the top level by bind.
// Depends on mvsm_pkg.
module mvsm_checker import mvsm_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [KIND_W-1:0]        rsp_result_kind,
   input logic signed [WORD_W-1:0] rsp_mixed_sample,
   input logic                     rsp_frame_end,
   input logic [SLOT_W-1:0]        rsp_voice_slot
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_kind)
         && $stable(rsp_mixed_sample) && $stable(rsp_frame_end) && $stable(rsp_voice_slot))
      else $error("response changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_flush_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == KIND_FLUSH)
         |-> rsp_frame_end && (rsp_mixed_sample == '0) && (rsp_voice_slot == '0))
      else $error("flush marker has wrong fields");

   a_play_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_result_kind == KIND_STARTED) || (rsp_result_kind == KIND_UNKNOWN)
         || (rsp_result_kind == KIND_NO_VOICE))
         |-> !rsp_frame_end && (rsp_mixed_sample == '0))
      else $error("play result carries sample or frame end");

   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_result_kind == KIND_SAMPLE) || (rsp_result_kind == KIND_UNKNOWN)
         || (rsp_result_kind == KIND_NO_VOICE))
         |-> (rsp_voice_slot == '0))
      else $error("voice slot set on a result without a started voice");

endmodule

bind multi_voice_sample_mixer mvsm_checker u_mvsm_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_result_kind  (rsp.result_kind),
   .rsp_mixed_sample (rsp.mixed_sample),
   .rsp_frame_end    (rsp.frame_end),
   .rsp_voice_slot   (rsp.voice_slot)
);

[dv/mvsm_tb_if.sv]
// Testbench-side notes: the channel interfaces come from the RTL file mvsm_if.sv.
// This file holds a small package of stimulus helpers; depends on mvsm_pkg.
package mvsm_tb_pkg;
   import mvsm_pkg::*;

   // One command as the stimulus side builds it.
   typedef struct {
      logic [OPCODE_W-1:0]      opcode;
      logic [ADDR_W-1:0]        mem_address;
      logic signed [WORD_W-1:0] sample_word;
      logic [SOUND_W-1:0]       sound_number;
      logic [START_W-1:0]       sound_start;
      logic [SIZE_W-1:0]        sound_size;
      logic [SPEED_W-1:0]       play_speed;
   } mix_cmd_type;

   // One result of the mixer.
   typedef struct {
      logic [KIND_W-1:0]        kind;
      logic signed [WORD_W-1:0] sample;
      logic                     frame_end;
      logic [SLOT_W-1:0]        slot;
   } mix_result_type;
endpackage

[dv/tb.sv]
// Self-checking testbench of multi_voice_sample_mixer: directed tests, then
// random command streams, each checked against a behavioral predictor.
// Depends on mvsm_pkg, mvsm_if (RTL) and mvsm_tb_pkg.
module tb;
   import mvsm_pkg::*;
   import mvsm_tb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   mvsm_req_if req ();
   mvsm_rsp_if rsp ();

   multi_voice_sample_mixer i_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   // Predictor state: a mirror of what the mixer holds.
   logic signed [15:0] sample_mem [0:SAMPLE_WORDS-1];
   bit                 sample_written [0:SAMPLE_WORDS-1];
   bit                 snd_defined [SOUND_COUNT];
   logic [START_W-1:0] snd_start [SOUND_COUNT];
   logic [SIZE_W-1:0]  snd_size [SOUND_COUNT];
   bit                 vc_in_use [VOICE_COUNT];
   logic [SOUND_W-1:0] vc_sound [VOICE_COUNT];
   logic [POS_W-1:0]   vc_pos [VOICE_COUNT];
   logic [SPEED_W-1:0] vc_speed [VOICE_COUNT];
   int unsigned        frame_count;
   int unsigned        frame_len;

   mix_result_type expected_results [$];
   int mismatches = 0;
   int results_seen = 0;
   int ticks_sent = 0;
   int sender_idle_pct = 30;   // Zero gives a stretch with no gaps.
   int sink_idle_pct = 30;

   // Sample addresses the random part may safely read.
   localparam int POOL_BASE = 16'hF000;
   localparam int POOL_SIZE = 128;

   // A voice plays while its position is still inside its sound.
   function automatic bit voice_playing(int v);
      if (!vc_in_use[v] || !snd_defined[vc_sound[v]]) return 0;
      return vc_pos[v] < ({17'd0, snd_size[vc_sound[v]]} << FRACTION_BITS);
   endfunction

   // Applies one command to the mirror and queues the result it causes.
   function automatic void predict_mix(mix_cmd_type c);
      mix_result_type r;
      int acc;
      int smp;
      int fl;
      logic [15:0] a;
      r.kind = KIND_SAMPLE; r.sample = '0; r.frame_end = 1'b0; r.slot = '0;
      case (c.opcode)
         OP_WRITE_SAMPLE: begin
            sample_mem[c.mem_address] = c.sample_word;
            sample_written[c.mem_address] = 1;
            return;
         end
         OP_DEFINE_SOUND: begin
            snd_defined[c.sound_number] = 1;
            snd_start[c.sound_number] = c.sound_start;
            snd_size[c.sound_number] = c.sound_size;
            return;
         end
         OP_PLAY: begin
            if (!snd_defined[c.sound_number]) begin
               r.kind = KIND_UNKNOWN;
            end else begin
               r.kind = KIND_NO_VOICE;
               for (int v = 0; v < VOICE_COUNT; v++) begin
                  if (!voice_playing(v)) begin
                     vc_in_use[v] = 1;
                     vc_sound[v] = c.sound_number;
                     vc_pos[v] = '0;
                     vc_speed[v] = c.play_speed;
                     r.kind = KIND_STARTED;
                     r.slot = SLOT_W'(v);
                     break;
                  end
               end
            end
         end
         OP_TICK: begin
            acc = 0;
            fl = (frame_len == 0) ? 1 : (frame_len > 8192 ? 8192 : frame_len);
            for (int v = 0; v < VOICE_COUNT; v++) begin
               if (voice_playing(v)) begin
                  a = 16'(snd_start[vc_sound[v]] + vc_pos[v][POS_W-1:FRACTION_BITS]);
                  smp = sample_written[a] ? int'(sample_mem[a]) : 0;
                  if (!sample_written[a])
                     $display("stimulus error: unwritten sample read at %0h", a);
                  acc = (2 * acc + smp) / 2;
                  if (acc > 32767) acc = 32767;
                  if (acc < -32768) acc = -32768;
                  vc_pos[v] = vc_pos[v] + POS_W'(vc_speed[v]);
               end
            end
            frame_count++;
            if (frame_count >= fl) begin
               frame_count = 0;
               r.frame_end = 1'b1;
            end
            r.sample = acc[15:0];
         end
         OP_FLUSH: begin
            frame_count = 0;
            r.kind = KIND_FLUSH;
            r.frame_end = 1'b1;
         end
         default: return;
      endcase
      expected_results.push_back(r);
   endfunction

   // Sends one command transaction, with random gaps before it. Valid stays
   // up after the accepting edge until a gap or the next command replaces it.
   task automatic send_command(mix_cmd_type c);
      while ($urandom_range(99) < sender_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid        <= 1'b1;
      req.opcode       <= c.opcode;
      req.mem_address  <= c.mem_address;
      req.sample_word  <= c.sample_word;
      req.sound_number <= c.sound_number;
      req.sound_start  <= c.sound_start;
      req.sound_size   <= c.sound_size;
      req.play_speed   <= c.play_speed;
      do @(posedge clock); while (!req.ready);
      predict_mix(c);
   endtask

   function automatic mix_cmd_type make_cmd(logic [2:0] op);
      mix_cmd_type c;
      c.opcode = op;
      c.mem_address = ADDR_W'($urandom);
      c.sample_word = WORD_W'($urandom);
      c.sound_number = SOUND_W'($urandom);
      c.sound_start = START_W'($urandom);
      c.sound_size = SIZE_W'($urandom);
      c.play_speed = SPEED_W'($urandom);
      return c;
   endfunction

   task automatic wait_drained();
      req.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   // Writes the frame length register while the mixer is idle.
   task automatic write_frame_length(int unsigned value);
      wait_drained();
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= {CSR_FRAME_LENGTH, 2'b00}; pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      frame_len = value & 32'h3FFF;
      @(posedge clock);
   endtask

   // Result checker: the sink stalls at random and compares each transaction.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            mix_result_type e;
            results_seen++;
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result kind %0d", rsp.result_kind);
            end else begin
               e = expected_results.pop_front();
               if (e.kind !== rsp.result_kind || e.sample !== rsp.mixed_sample ||
                   e.frame_end !== rsp.frame_end || e.slot !== rsp.voice_slot) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected kind %0d smp %0d fe %0b slot %0d, %s %0d %0d %0b %0d",
                              e.kind, e.sample, e.frame_end, e.slot, "got",
                              rsp.result_kind, rsp.mixed_sample, rsp.frame_end, rsp.voice_slot);
               end
            end
         end
         rsp.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
   end

   // Fills a pool of samples that the random sounds always stay inside.
   task automatic fill_pool();
      mix_cmd_type c;
      for (int i = 0; i < POOL_SIZE; i++) begin
         c = make_cmd(OP_WRITE_SAMPLE);
         c.mem_address = ADDR_W'(POOL_BASE + i);
         if (i < 8) c.sample_word = (i % 2) ? 16'sh7FFF : 16'sh8000;
         send_command(c);
      end
   endtask

   // Directed: field extremes, every operation and the special cases.
   task automatic test_directed();
      mix_cmd_type c;
      c = make_cmd(OP_PLAY); c.sound_number = 63; send_command(c);  // unknown sound
      c = make_cmd(OP_TICK); send_command(c);                         // no voices
      c = make_cmd(OP_FLUSH); send_command(c);
      c = make_cmd(3'd5); send_command(c);                            // ignored opcodes
      c = make_cmd(3'd7); send_command(c);
      // Address wrap: a sound starting at the top of memory runs into address zero.
      c = make_cmd(OP_WRITE_SAMPLE); c.mem_address = 16'hFFFF; c.sample_word = 16'sh7FFF;
      send_command(c);
      c = make_cmd(OP_WRITE_SAMPLE); c.mem_address = 16'h0000; c.sample_word = 16'sh8000;
      send_command(c);
      c = make_cmd(OP_DEFINE_SOUND); c.sound_number = 63; c.sound_start = 16'hFFFF;
      c.sound_size = 2; send_command(c);
      c = make_cmd(OP_PLAY); c.sound_number = 63; c.play_speed = 20'h10000; send_command(c);
      c = make_cmd(OP_PLAY); c.sound_number = 63; c.play_speed = 20'hFFFFF; send_command(c);
      // Zero-size sound finishes at once; zero speed never finishes.
      c = make_cmd(OP_DEFINE_SOUND); c.sound_number = 0; c.sound_start = 16'hFFFF;
      c.sound_size = 0; send_command(c);
      c = make_cmd(OP_PLAY); c.sound_number = 0; send_command(c);
      c = make_cmd(OP_DEFINE_SOUND); c.sound_number = 1; c.sound_start = 16'hFFFF;
      c.sound_size = 17'h10000; send_command(c);
      for (int i = 0; i < 3; i++) begin
         c = make_cmd(OP_TICK); send_command(c);
      end
      // Fill every slot with zero-speed voices to saturate and exhaust slots.
      for (int i = 0; i < VOICE_COUNT + 1; i++) begin
         c = make_cmd(OP_PLAY); c.sound_number = 1; c.play_speed = 0; send_command(c);
      end
      c = make_cmd(OP_TICK); send_command(c);
      // Redefinition ends the zero-speed voices so slots come free again.
      c = make_cmd(OP_DEFINE_SOUND); c.sound_number = 1; c.sound_start = START_W'(POOL_BASE);
      c.sound_size = 0; send_command(c);
   endtask

   // Random streams of well-formed sounds over the sample pool, plus noise.
   task automatic test_random(int count);
      mix_cmd_type c;
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 45) c = make_cmd(OP_TICK);
         else if (pick < 65) c = make_cmd(OP_PLAY);
         else if (pick < 78) begin
            c = make_cmd(OP_DEFINE_SOUND);
            c.sound_start = START_W'(POOL_BASE + $urandom_range(POOL_SIZE - 1));
            c.sound_size = SIZE_W'($urandom_range(POOL_BASE + POOL_SIZE - c.sound_start));
            if ($urandom_range(9) == 0) c.sound_size = 0;
         end else if (pick < 85) begin
            c = make_cmd(OP_WRITE_SAMPLE);
            if ($urandom_range(1))
               c.mem_address = ADDR_W'(POOL_BASE + $urandom_range(POOL_SIZE - 1));
         end else if (pick < 90) c = make_cmd(OP_FLUSH);
         else if (pick < 93) c = make_cmd(3'(5 + $urandom_range(2)));
         else begin
            c = make_cmd(OP_PLAY); c.sound_number = SOUND_W'($urandom_range(SOUND_COUNT - 1));
         end
         if (c.opcode == OP_PLAY && $urandom_range(3) != 0)
            c.play_speed = SPEED_W'($urandom_range(20'h30000));
         if (c.opcode == OP_TICK) ticks_sent++;
         send_command(c);
      end
   endtask

   initial begin
      req.valid = 1'b0; req.opcode = '0; req.mem_address = '0; req.sample_word = '0;
      req.sound_number = '0; req.sound_start = '0; req.sound_size = '0;
      req.play_speed = '0;
      for (int i = 0; i < SAMPLE_WORDS; i++) sample_written[i] = 0;
      foreach (snd_defined[i]) snd_defined[i] = 0;
      foreach (vc_in_use[i]) vc_in_use[i] = 0;
      frame_count = 0;
      frame_len = FRAME_LEN_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      fill_pool();
      test_directed();
      // Frame length settings: small, zero (acts as one), top and out of range.
      write_frame_length(1);
      test_random(150);
      write_frame_length(0);
      test_random(100);
      sender_idle_pct = 0; sink_idle_pct = 0;
      write_frame_length(8192);
      test_random(150);
      sender_idle_pct = 30; sink_idle_pct = 30;
      write_frame_length(16383);
      test_random(100);
      write_frame_length(7);
      // The sender holds off until the mixer has answered everything.
      wait_drained();
      test_random(200);
      write_frame_length(3);
      test_random(180);

      wait_drained();
      $display("Covered %0d results including %0d ticks across six frame lengths.",
               results_seen, ticks_sent);
      if (mismatches == 0 && expected_results.size() == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

   initial begin
      #5ms;
      $display("tb NOT OK");
      $finish;
   end
endmodule
